FILE: rtl/core/lcd_command_pixel_writer_assert.svh
// ----------------------------------------------------------------------------
// LCD command pixel writer assertion macros
// Concurrent assertion shorthands clocked on clk; NOW, NEXT disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_COMMAND_PIXEL_WRITER_ASSERT_SVH
`define LCD_COMMAND_PIXEL_WRITER_ASSERT_SVH

// Same-cycle implication.
`define LCPW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcpw assertion failed");

// Next-cycle implication.
`define LCPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcpw assertion failed");

// Check that holds in and out of reset.
`define LCPW_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("lcpw assertion failed");

`endif

FILE: rtl/core/lcpw_pkg.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer package
// Command codes, result kinds, result record and color conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcpw_pkg;

  localparam logic       OP_COMMAND = 1'b0;
  localparam logic       OP_DATA    = 1'b1;

  localparam logic [7:0] CMD_SCROLL    = 8'h37;
  localparam logic [7:0] CMD_RAM_START = 8'h2C;
  localparam logic [7:0] CMD_RAM_CONT  = 8'h3C;
  localparam logic [7:0] CMD_COLUMN    = 8'h2A;
  localparam logic [7:0] CMD_PAGE      = 8'h2B;

  localparam logic [4:0] PARAM_LIMIT = 5'd24;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] column;
    logic [15:0] row;
    logic [23:0] color;
    logic [15:0] scroll_pos;
  } res_t;

  function automatic logic [23:0] rgb565_to_888(input logic [15:0] w);
    return {w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
  endfunction

endpackage

FILE: rtl/core/lcpw_bus_if.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer channels
// Bus item channel and result channel with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcpw_bus_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface lcpw_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] column;
  logic [15:0] row;
  logic [23:0] color;
  logic [15:0] scroll_pos;

  modport source (output valid, output kind, output column, output row,
                  output color, output scroll_pos, input ready);
  modport sink   (input valid, input kind, input column, input row,
                  input color, input scroll_pos, output ready);
endinterface

FILE: rtl/core/lcpw_ctrl.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer control
// Command decode, parameter collection, window registers and write pointer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          operation,
  input  logic [15:0]   value,
  output logic          res_valid,
  output lcpw_pkg::res_t res
);
  import lcpw_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RAM,
    MODE_COLLECT,
    MODE_DONE
  } mode_t;

  mode_t       mode, mode_next, mode_eff;
  logic [4:0]  param_count, param_count_next;
  logic [7:0]  byte0, byte1, byte2;
  logic [7:0]  byte0_next, byte1_next, byte2_next;
  logic [7:0]  current_command, current_command_next;
  logic [15:0] column_start, column_start_next;
  logic [15:0] column_end, column_end_next;
  logic [15:0] page_start, page_start_next;
  logic [15:0] page_end, page_end_next;
  logic [15:0] next_column, next_column_next;
  logic [15:0] next_page, next_page_next;
  logic        write_enable, write_enable_next;
  logic [15:0] column_inc, page_inc;

  assign column_inc = next_column + 16'd1;
  assign page_inc   = next_page + 16'd1;

  always_comb begin
    mode_next            = mode;
    mode_eff             = mode;
    param_count_next     = param_count;
    byte0_next           = byte0;
    byte1_next           = byte1;
    byte2_next           = byte2;
    current_command_next = current_command;
    column_start_next    = column_start;
    column_end_next      = column_end;
    page_start_next      = page_start;
    page_end_next        = page_end;
    next_column_next     = next_column;
    next_page_next       = next_page;
    write_enable_next    = write_enable;
    res_valid            = 1'b0;
    res                  = '0;

    if (accept) begin
      if (operation == OP_COMMAND) begin
        write_enable_next    = 1'b1;
        param_count_next     = '0;
        current_command_next = value[7:0];
        if (value[7:0] == CMD_RAM_START) begin
          next_page_next   = page_start;
          next_column_next = column_start;
          mode_next        = MODE_RAM;
        end else begin
          mode_next = MODE_IDLE;
        end
      end else if (mode != MODE_DONE) begin
        if (mode == MODE_IDLE) begin
          mode_eff = (current_command == CMD_RAM_CONT) ? MODE_RAM : MODE_COLLECT;
        end
        mode_next = mode_eff;
        if (mode_eff == MODE_RAM) begin
          if (write_enable) begin
            res_valid  = 1'b1;
            res.kind   = KIND_PIXEL;
            res.column = next_column;
            res.row    = next_page;
            res.color  = rgb565_to_888(value);
            if (column_inc > column_end) begin
              next_column_next = column_start;
              next_page_next   = page_inc;
              if (page_inc > page_end) begin
                write_enable_next = 1'b0;
              end
            end else begin
              next_column_next = column_inc;
            end
          end
        end else if (param_count < PARAM_LIMIT) begin
          param_count_next = param_count + 5'd1;
          case (param_count)
            5'd0:    byte0_next = value[7:0];
            5'd1:    byte1_next = value[7:0];
            5'd2:    byte2_next = value[7:0];
            default: ;
          endcase
          unique case (current_command)
            CMD_SCROLL: begin
              if (param_count == 5'd1) begin
                res_valid      = 1'b1;
                res.kind       = KIND_SCROLL;
                res.scroll_pos = {byte0, value[7:0]};
                mode_next      = MODE_DONE;
              end
            end
            CMD_COLUMN: begin
              if (param_count == 5'd3) begin
                column_start_next = {byte0, byte1};
                column_end_next   = {byte2, value[7:0]};
                mode_next         = MODE_DONE;
              end
            end
            CMD_PAGE: begin
              if (param_count == 5'd3) begin
                page_start_next = {byte0, byte1};
                page_end_next   = {byte2, value[7:0]};
                mode_next       = MODE_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      param_count     <= '0;
      current_command <= '0;
      column_start    <= '0;
      column_end      <= '0;
      page_start      <= '0;
      page_end        <= '0;
      next_column     <= '0;
      next_page       <= '0;
      write_enable    <= 1'b1;
    end else begin
      mode            <= mode_next;
      param_count     <= param_count_next;
      current_command <= current_command_next;
      column_start    <= column_start_next;
      column_end      <= column_end_next;
      page_start      <= page_start_next;
      page_end        <= page_end_next;
      next_column     <= next_column_next;
      next_page       <= next_page_next;
      write_enable    <= write_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    byte0 <= byte0_next;
    byte1 <= byte1_next;
    byte2 <= byte2_next;
  end

endmodule

FILE: rtl/core/lcpw_out.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer output stage
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpw_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcpw_pkg::res_t push_data,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output lcpw_pkg::res_t out_data
);
  import lcpw_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid && out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/lcd_command_pixel_writer.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer
// Turns a stream of LCD command and data transfers into pixel writes and
// scroll position updates.
// ----------------------------------------------------------------------------
// One bus transfer is taken each unstalled cycle: each item is decoded in the
// cycle it is transferred. Its result, if any, is in the result register on
// the next cycle when that register is empty or being drained; otherwise it
// waits in the skid entry and moves up once the held result is transferred.
// The bus keeps transferring while a result waits; bus.ready drops only when
// both the result register and the skid entry hold results. Window commands
// (0x2A, 0x2B) take four parameter bytes, scroll (0x37) takes two and
// produces a scroll result, and after 0x2C or 0x3C every data word produces
// an RGB888 pixel write at the walking pointer until the window is exhausted.
`timescale 1ns / 1ps

module lcd_command_pixel_writer (
  input logic        clk,
  input logic        rst,
  lcpw_bus_if.sink   bus,
  lcpw_res_if.source result
);
  import lcpw_pkg::*;

  logic accept;
  logic room;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign bus.ready = room;
  assign accept    = bus.valid && room;

  lcpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (bus.operation),
    .value     (bus.value),
    .res_valid (res_valid),
    .res       (res)
  );

  lcpw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.kind       = out_data.kind;
  assign result.column     = out_data.column;
  assign result.row        = out_data.row;
  assign result.color      = out_data.color;
  assign result.scroll_pos = out_data.scroll_pos;

endmodule

FILE: rtl/core/lcpw_checker.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer checker
// Port-level checks on result fields, backpressure and reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_command_pixel_writer_assert.svh"

module lcpw_checker (
  input logic        clk,
  input logic        rst,
  input logic        bus_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic [15:0] column,
  input logic [15:0] row,
  input logic [23:0] color,
  input logic [15:0] scroll_pos
);
  import lcpw_pkg::*;

  `LCPW_ASSERT_NOW(scroll_fields_zero, res_valid && kind == KIND_SCROLL, column == 16'd0 && row == 16'd0 && color == 24'd0)
  `LCPW_ASSERT_NOW(pixel_fields_clean, res_valid && kind == KIND_PIXEL, scroll_pos == 16'd0 && color[18:16] == 3'd0 && color[9:8] == 2'd0 && color[2:0] == 3'd0)
  `LCPW_ASSERT_NOW(stall_only_when_full, !bus_ready, res_valid)
  `LCPW_ASSERT_NEXT(result_held, res_valid && !res_ready, res_valid && $stable(column) && $stable(row) && $stable(color) && $stable(scroll_pos))
  `LCPW_ASSERT_ALWAYS(idle_after_reset, $past(rst), !res_valid && bus_ready)

endmodule

bind lcd_command_pixel_writer lcpw_checker u_lcpw_checker (
  .clk        (clk),
  .rst        (rst),
  .bus_ready  (bus.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .kind       (result.kind),
  .column     (result.column),
  .row        (result.row),
  .color      (result.color),
  .scroll_pos (result.scroll_pos)
);

FILE: bench/tb_lcd_command_pixel_writer.sv
// ----------------------------------------------------------------------------
// LCD command pixel writer testbench
// Drives command and data transfers with random gaps and result stalls, tracks
// window, pointer and scroll state in a predictor, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_command_pixel_writer;
  import lcpw_pkg::*;

  localparam int ITEM_TARGET    = 625;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAM,
    ST_COLLECT,
    ST_DONE
  } writer_state_t;

  class lcd_frame_predictor;
    res_t          pending_writes[$];
    int unsigned   errors;
    int unsigned   pixels_seen;
    int unsigned   scrolls_seen;
    writer_state_t state;
    logic [4:0]    n_params;
    logic [7:0]    params[4];
    logic [7:0]    cmd;
    logic [15:0]   col_lo, col_hi, page_lo, page_hi;
    logic [15:0]   col_ptr, page_ptr;
    logic          wr_en;

    function new();
      state    = ST_IDLE;
      n_params = '0;
      foreach (params[i]) params[i] = '0;
      cmd      = '0;
      col_lo   = '0;
      col_hi   = '0;
      page_lo  = '0;
      page_hi  = '0;
      col_ptr  = '0;
      page_ptr = '0;
      wr_en    = 1'b1;
    endfunction

    function void take_bus_transfer(logic op, logic [15:0] value);
      res_t r;
      if (op == OP_COMMAND) begin
        wr_en    = 1'b1;
        n_params = '0;
        cmd      = value[7:0];
        if (cmd == CMD_RAM_START) begin
          page_ptr = page_lo;
          col_ptr  = col_lo;
          state    = ST_RAM;
        end else begin
          state = ST_IDLE;
        end
        return;
      end
      if (state == ST_DONE) return;
      if (state == ST_IDLE) state = (cmd == CMD_RAM_CONT) ? ST_RAM : ST_COLLECT;
      if (state == ST_RAM) begin
        if ((cmd == CMD_RAM_START || cmd == CMD_RAM_CONT) && wr_en) begin
          r.kind       = KIND_PIXEL;
          r.column     = col_ptr;
          r.row        = page_ptr;
          r.color      = (24'(value & 16'hF800) >> 8) << 16 |
                         (24'(value & 16'h07E0) >> 3) << 8 |
                         (24'(value & 16'h001F) << 3);
          r.scroll_pos = '0;
          pending_writes.push_back(r);
          col_ptr = col_ptr + 16'd1;
          if (col_ptr > col_hi) begin
            col_ptr  = col_lo;
            page_ptr = page_ptr + 16'd1;
            if (page_ptr > page_hi) wr_en = 1'b0;
          end
        end
        return;
      end
      if (n_params >= PARAM_LIMIT) return;
      if (n_params < 5'd4) params[n_params[1:0]] = value[7:0];
      n_params = n_params + 5'd1;
      case (cmd)
        CMD_SCROLL: begin
          if (n_params == 5'd2) begin
            r.kind       = KIND_SCROLL;
            r.column     = '0;
            r.row        = '0;
            r.color      = '0;
            r.scroll_pos = {params[0], params[1]};
            pending_writes.push_back(r);
            state = ST_DONE;
          end
        end
        CMD_COLUMN: begin
          if (n_params == 5'd4) begin
            col_lo = {params[0], params[1]};
            col_hi = {params[2], params[3]};
            state  = ST_DONE;
          end
        end
        CMD_PAGE: begin
          if (n_params == 5'd4) begin
            page_lo = {params[0], params[1]};
            page_hi = {params[2], params[3]};
            state   = ST_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task match_result(res_t got);
      res_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_writes.pop_front();
      if (want.kind == KIND_PIXEL) pixels_seen++;
      else scrolls_seen++;
      if (got.kind !== want.kind)
        report($sformatf("kind got %0b want %0b", got.kind, want.kind));
      if (got.column !== want.column)
        report($sformatf("column got %h want %h", got.column, want.column));
      if (got.row !== want.row)
        report($sformatf("row got %h want %h", got.row, want.row));
      if (got.color !== want.color)
        report($sformatf("color got %h want %h", got.color, want.color));
      if (got.scroll_pos !== want.scroll_pos)
        report($sformatf("scroll_pos got %h want %h", got.scroll_pos, want.scroll_pos));
    endtask
  endclass

  logic clk;
  logic rst;

  lcpw_bus_if bus_ch ();
  lcpw_res_if res_ch ();

  lcd_command_pixel_writer dut (
    .clk    (clk),
    .rst    (rst),
    .bus    (bus_ch),
    .result (res_ch)
  );

  lcd_frame_predictor frame;
  res_t               seen_res;
  int                 items_sent;
  int                 idle_cycles;
  int                 src_level;
  int                 snk_level;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_draw(int level);
    case (level)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic logic [15:0] with_junk(logic [7:0] b);
    logic [7:0] hi;
    hi = 8'($urandom);
    return {hi, b};
  endfunction

  function automatic logic [7:0] pick_unknown_code();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CMD_SCROLL || c == CMD_RAM_START || c == CMD_RAM_CONT ||
           c == CMD_COLUMN || c == CMD_PAGE);
    return c;
  endfunction

  task automatic send_item(input logic op, input logic [15:0] value);
    int gap;
    gap = idle_draw(src_level);
    @(negedge clk);
    if (gap != 0) begin
      bus_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bus_ch.valid     <= 1'b1;
    bus_ch.operation <= op;
    bus_ch.value     <= value;
    do @(posedge clk); while (!bus_ch.ready);
    items_sent++;
  endtask

  task automatic send_command(input logic [7:0] code);
    send_item(OP_COMMAND, with_junk(code));
  endtask

  task automatic pick_window(output logic [15:0] lo, output logic [15:0] hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = 16'($urandom_range(8, 400));
        hi = lo - 16'($urandom_range(1, 8));
      end
      1: begin
        hi = 16'hFFFF;
        lo = hi - 16'($urandom_range(0, 3));
      end
      2: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      default: begin
        lo = 16'($urandom_range(0, 300));
        hi = lo + 16'($urandom_range(0, 7));
      end
    endcase
  endtask

  task automatic window_seq(input logic [7:0] code);
    logic [15:0] lo, hi;
    logic [7:0]  bytes[4];
    int          n;
    pick_window(lo, hi);
    bytes = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
    send_command(code);
    for (int i = 0; i < n; i++) send_item(OP_DATA, with_junk(bytes[i]));
    if (n == 4) repeat ($urandom_range(0, 2)) send_item(OP_DATA, 16'($urandom));
  endtask

  task automatic run_sequence();
    int n;
    if ($urandom_range(0, 7) == 0) src_level = $urandom_range(0, 2);
    case ($urandom_range(0, 15))
      0, 1: window_seq(CMD_COLUMN);
      2, 3: window_seq(CMD_PAGE);
      4, 5, 6, 7, 8, 9: begin
        send_command(($urandom_range(0, 2) == 0) ? CMD_RAM_CONT : CMD_RAM_START);
        repeat ($urandom_range(1, 24)) send_item(OP_DATA, 16'($urandom));
      end
      10: begin
        n = ($urandom_range(0, 4) == 0) ? 1 : 2 + $urandom_range(0, 2);
        send_command(CMD_SCROLL);
        repeat (n) send_item(OP_DATA, 16'($urandom));
      end
      11, 12: begin
        send_command(pick_unknown_code());
        repeat ($urandom_range(0, 30)) send_item(OP_DATA, 16'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 4)) send_item(1'($urandom), 16'($urandom));
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        seen_res.kind       = res_ch.kind;
        seen_res.column     = res_ch.column;
        seen_res.row        = res_ch.row;
        seen_res.color      = res_ch.color;
        seen_res.scroll_pos = res_ch.scroll_pos;
        frame.match_result(seen_res);
      end
      if (bus_ch.valid && bus_ch.ready)
        frame.take_bus_transfer(bus_ch.operation, bus_ch.value);
      if ((res_ch.valid && res_ch.ready) || (bus_ch.valid && bus_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) snk_level = $urandom_range(0, 2);
      stall = idle_draw(snk_level);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    frame            = new();
    rst              = 1'b1;
    bus_ch.valid     = 1'b0;
    bus_ch.operation = OP_COMMAND;
    bus_ch.value     = '0;
    items_sent       = 0;
    idle_cycles      = 0;
    src_level        = 0;
    snk_level        = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // data before any command, then a 2x2 window and one pixel past its end
    send_item(OP_DATA, 16'hFFFF);
    send_command(CMD_COLUMN);
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h01));
    send_command(CMD_PAGE);
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h00));
    send_item(OP_DATA, with_junk(8'h01));
    send_command(CMD_RAM_START);
    send_item(OP_DATA, 16'hFFFF);
    send_item(OP_DATA, 16'h0000);
    send_item(OP_DATA, 16'hF800);
    send_item(OP_DATA, 16'h07E0);
    send_item(OP_DATA, 16'h001F);
    // scroll at the top value, then trailing data that must be dropped
    send_command(CMD_SCROLL);
    send_item(OP_DATA, 16'h00FF);
    send_item(OP_DATA, 16'hFFFF);
    send_item(OP_DATA, 16'h1234);
    // continue from the exhausted pointer
    send_command(CMD_RAM_CONT);
    send_item(OP_DATA, 16'hAAAA);
    send_item(OP_DATA, 16'h5555);

    src_level = 2;
    snk_level = 1;
    while (items_sent < ITEM_TARGET) run_sequence();
    @(negedge clk);
    bus_ch.valid <= 1'b0;

    while (frame.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bus transfers, %0d pixel writes and %0d scroll updates",
             items_sent, frame.pixels_seen, frame.scrolls_seen);
    $display("mismatches found: %0d", frame.errors);
    if (frame.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
